// File: src/rumble_motor_pwm_driver_assert.svh
// Assertion macros shared by the rumble motor driver RTL.
`ifndef RUMBLE_MOTOR_PWM_DRIVER_ASSERT_SVH
`define RUMBLE_MOTOR_PWM_DRIVER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define RMPD_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rumble driver: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define RMPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rumble driver: next-cycle check failed");

`endif

// File: src/rmpd_pkg.sv
// Types, constants and arithmetic helpers for the rumble motor driver.
package rmpd_pkg;

	localparam int LEVEL_W  = 16;
	localparam int REMAIN_W = 26;

	localparam logic [LEVEL_W-1:0] FULL_LEVEL = 16'hFFFF;

	// Request opcodes
	localparam logic OP_COMMAND = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	// Configuration register indexes
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_DRIVE_ENABLE     = 3'd0;
	localparam cfg_idx_t CFG_INTENSITY        = 3'd1;
	localparam cfg_idx_t CFG_STEADY_THRESHOLD = 3'd2;
	localparam cfg_idx_t CFG_PULSE_PERIOD     = 3'd3;
	localparam cfg_idx_t CFG_STRONG_FLOOR     = 3'd4;
	localparam cfg_idx_t CFG_WEAK_FLOOR       = 3'd5;

	// Register values after reset
	localparam logic               RST_DRIVE_ENABLE     = 1'b1;
	localparam logic [7:0]         RST_INTENSITY        = 8'd255;
	localparam logic [LEVEL_W-1:0] RST_STEADY_THRESHOLD = 16'd60000;
	localparam logic [LEVEL_W-1:0] RST_PULSE_PERIOD     = 16'd8000;
	localparam logic [LEVEL_W-1:0] RST_STRONG_FLOOR     = 16'd16384;
	localparam logic [LEVEL_W-1:0] RST_WEAK_FLOOR       = 16'd8192;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_STEADY = 2'd1,
		MODE_PULSED = 2'd2
	} mode_t;

	// What the back end has to do with a request
	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_HOLD = 2'd1,
		KIND_STOP = 2'd2,
		KIND_RUN  = 2'd3
	} kind_t;

	typedef struct packed {
		logic               drive_enable;
		logic [7:0]         intensity;
		logic [LEVEL_W-1:0] steady_threshold;
		logic [LEVEL_W-1:0] pulse_period_us;
		logic [LEVEL_W-1:0] strong_floor;
		logic [LEVEL_W-1:0] weak_floor;
	} cfg_t;

	typedef struct packed {
		kind_t               kind;
		logic [LEVEL_W-1:0]  strong_level;
		logic [LEVEL_W-1:0]  weak_level;
		logic [REMAIN_W-1:0] remaining_us;
	} item_t;

	typedef struct packed {
		mode_t mode;
		logic  rem_zero;
	} back_status_t;

	// A period of zero behaves as one microsecond
	function automatic logic [LEVEL_W-1:0] eff_period(input logic [LEVEL_W-1:0] p);
		return (p == '0) ? 16'd1 : p;
	endfunction

	// Raise a nonzero level to its floor
	function automatic logic [LEVEL_W-1:0] apply_floor(input logic [LEVEL_W-1:0] v,
			input logic [LEVEL_W-1:0] fl);
		return (v != '0 && v < fl) ? fl : v;
	endfunction

	// Milliseconds to microseconds: d*1024 - d*16 - d*8
	function automatic logic [REMAIN_W-1:0] ms_to_us(input logic [LEVEL_W-1:0] d);
		logic [REMAIN_W-1:0] x;
		x = {10'd0, d};
		return (x << 10) - (x << 4) - (x << 3);
	endfunction

	// Estimate of x/255, at most one below the true quotient
	function automatic logic [LEVEL_W-1:0] div255_est(input logic [23:0] x);
		logic [24:0] sum;
		sum = {1'b0, x} + {9'd0, x[23:8]} + {17'd0, x[23:16]};
		return sum[23:8];
	endfunction

	// Correct the estimate by one step of compare and add
	function automatic logic [LEVEL_W-1:0] div255_fix(input logic [23:0] x,
			input logic [LEVEL_W-1:0] q0);
		logic [23:0] r;
		r = x - {q0, 8'd0} + {8'd0, q0};
		return (r >= 24'd255) ? q0 + 16'd1 : q0;
	endfunction

	// Estimate of x/65535, at most one below the true quotient
	function automatic logic [LEVEL_W-1:0] div65535_est(input logic [31:0] x);
		logic [32:0] sum;
		sum = {1'b0, x} + {17'd0, x[31:16]};
		return sum[31:16];
	endfunction

	function automatic logic [LEVEL_W-1:0] div65535_fix(input logic [31:0] x,
			input logic [LEVEL_W-1:0] q0);
		logic [31:0] r;
		r = x - {q0, 16'd0} + {16'd0, q0};
		return (r >= 32'd65535) ? q0 + 16'd1 : q0;
	endfunction

endpackage

// File: src/rmpd_if.sv
// Request and result channel interfaces of the rumble motor driver.
interface rmpd_in_if import rmpd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               op;
	logic [LEVEL_W-1:0] strong_level;
	logic [LEVEL_W-1:0] weak_level;
	logic [LEVEL_W-1:0] duration_ms;

	modport source (output valid, op, strong_level, weak_level, duration_ms, input ready);
	modport sink (input valid, op, strong_level, weak_level, duration_ms, output ready);
endinterface

interface rmpd_out_if import rmpd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               motor_on;
	logic [LEVEL_W-1:0] strong_drive;
	logic [LEVEL_W-1:0] weak_drive;
	logic [1:0]         drive_mode;

	modport source (output valid, motor_on, strong_drive, weak_drive, drive_mode, input ready);
	modport sink (input valid, motor_on, strong_drive, weak_drive, drive_mode, output ready);
endinterface

// File: src/rmpd_front.sv
// Front end: takes requests, classifies them and converts the duration.
module rmpd_front import rmpd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   drive_enable,
	rmpd_in_if.sink in_ch,
	output logic   push_valid,
	input  logic   push_ready,
	output item_t  push_item
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_d;
	logic  take;

	assign in_ch.ready = !valid_s1 || push_ready;
	assign take        = in_ch.valid && in_ch.ready;

	// Classify the incoming request
	always_comb begin
		item_d.strong_level = in_ch.strong_level;
		item_d.weak_level   = in_ch.weak_level;
		item_d.remaining_us = ms_to_us(in_ch.duration_ms);
		priority if (in_ch.op == OP_TICK) begin
			item_d.kind = KIND_TICK;
		end else if (!drive_enable) begin
			item_d.kind = KIND_HOLD;
		end else if (in_ch.duration_ms == '0) begin
			item_d.kind = KIND_STOP;
		end else begin
			item_d.kind = KIND_RUN;
		end
	end

	// Hold the classified request until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

// File: src/rmpd_queue.sv
// Short request queue between the front and back ends.
module rmpd_queue import rmpd_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the request
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: src/rmpd_back.sv
// Back end: drive sequencer that carries out commands and ticks.
module rmpd_back import rmpd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  item_t         pop_item,
	rmpd_out_if.source    out_ch,
	output back_status_t  status
);

	typedef enum logic [2:0] {
		ST_WAIT    = 3'd0,
		ST_DIVIDE  = 3'd1,
		ST_FLOOR   = 3'd2,
		ST_COMPARE = 3'd3,
		ST_ONDIV   = 3'd4,
		ST_ONFIX   = 3'd5,
		ST_SHOW    = 3'd6
	} state_t;

	state_t              state_q;
	mode_t               mode_q;
	logic [LEVEL_W-1:0]  steady_strong_q;
	logic [LEVEL_W-1:0]  steady_weak_q;
	logic [LEVEL_W-1:0]  on_time_q;
	logic [LEVEL_W-1:0]  phase_q;
	logic [REMAIN_W-1:0] remaining_q;

	// Command working registers
	logic [REMAIN_W-1:0] run_us_q;
	logic [23:0]         prod_s_q;
	logic [23:0]         prod_w_q;
	logic [LEVEL_W-1:0]  est_s_q;
	logic [LEVEL_W-1:0]  est_w_q;
	logic [LEVEL_W-1:0]  lvl_s_q;
	logic [LEVEL_W-1:0]  lvl_w_q;
	logic [31:0]         prod_on_q;
	logic [LEVEL_W-1:0]  est_on_q;

	// Output register
	logic                out_valid_q;
	logic                motor_on_q;
	logic [LEVEL_W-1:0]  strong_q;
	logic [LEVEL_W-1:0]  weak_q;
	mode_t               mode_out_q;

	logic [LEVEL_W-1:0]  per;
	logic [REMAIN_W-1:0] rem_dec;
	logic [LEVEL_W:0]    phase_inc;
	logic                period_end;
	logic [LEVEL_W-1:0]  s_fix;
	logic [LEVEL_W-1:0]  w_fix;
	logic [LEVEL_W-1:0]  mag;
	logic [LEVEL_W-1:0]  on_fix;
	logic                show_on;
	logic [LEVEL_W-1:0]  show_strong;
	logic [LEVEL_W-1:0]  show_weak;
	logic                out_free;

	// Datapath terms for the current step
	always_comb begin
		per        = eff_period(cfg.pulse_period_us);
		rem_dec    = (remaining_q != '0) ? remaining_q - 1'b1 : remaining_q;
		phase_inc  = {1'b0, phase_q} + 17'd1;
		period_end = phase_inc >= {1'b0, per};
		s_fix      = div255_fix(prod_s_q, est_s_q);
		w_fix      = div255_fix(prod_w_q, est_w_q);
		mag        = (lvl_s_q > lvl_w_q) ? lvl_s_q : lvl_w_q;
		on_fix     = div65535_fix(prod_on_q, est_on_q);
		show_on     = 1'b0;
		show_strong = '0;
		show_weak   = '0;
		if (mode_q == MODE_STEADY) begin
			show_on     = 1'b1;
			show_strong = steady_strong_q;
			show_weak   = steady_weak_q;
		end else if (mode_q == MODE_PULSED && phase_q < on_time_q) begin
			show_on     = 1'b1;
			show_strong = FULL_LEVEL;
			show_weak   = FULL_LEVEL;
		end
	end

	assign out_free  = !out_valid_q || out_ch.ready;
	assign pop_ready = state_q == ST_WAIT;

	// Sequencer, drive state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_WAIT;
			mode_q          <= MODE_IDLE;
			steady_strong_q <= '0;
			steady_weak_q   <= '0;
			on_time_q       <= '0;
			phase_q         <= '0;
			remaining_q     <= '0;
			run_us_q        <= '0;
			prod_s_q        <= '0;
			prod_w_q        <= '0;
			est_s_q         <= '0;
			est_w_q         <= '0;
			lvl_s_q         <= '0;
			lvl_w_q         <= '0;
			prod_on_q       <= '0;
			est_on_q        <= '0;
			out_valid_q     <= 1'b0;
			motor_on_q      <= 1'b0;
			strong_q        <= '0;
			weak_q          <= '0;
			mode_out_q      <= MODE_IDLE;
		end else begin
			// Drop the taken result unless a new one replaces it
			if (out_ch.ready && state_q != ST_SHOW) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_WAIT: begin
					if (pop_valid) begin
						unique case (pop_item.kind)
							KIND_TICK: begin
								if (mode_q == MODE_STEADY) begin
									remaining_q <= rem_dec;
									if (rem_dec == '0) begin
										mode_q <= MODE_IDLE;
									end
								end else if (mode_q == MODE_PULSED) begin
									remaining_q <= rem_dec;
									if (period_end) begin
										phase_q <= '0;
										if (rem_dec == '0) begin
											mode_q <= MODE_IDLE;
										end
									end else begin
										phase_q <= phase_inc[LEVEL_W-1:0];
									end
								end
								state_q <= ST_SHOW;
							end
							KIND_HOLD: begin
								state_q <= ST_SHOW;
							end
							KIND_STOP: begin
								mode_q      <= MODE_IDLE;
								remaining_q <= '0;
								phase_q     <= '0;
								state_q     <= ST_SHOW;
							end
							KIND_RUN: begin
								prod_s_q <= {8'd0, pop_item.strong_level} * {16'd0, cfg.intensity};
								prod_w_q <= {8'd0, pop_item.weak_level} * {16'd0, cfg.intensity};
								run_us_q <= pop_item.remaining_us;
								state_q  <= ST_DIVIDE;
							end
							default: begin
								state_q <= ST_SHOW;
							end
						endcase
					end
				end
				ST_DIVIDE: begin
					est_s_q <= div255_est(prod_s_q);
					est_w_q <= div255_est(prod_w_q);
					state_q <= ST_FLOOR;
				end
				ST_FLOOR: begin
					// Both scaled levels zero stops the motor
					if (s_fix == '0 && w_fix == '0) begin
						mode_q      <= MODE_IDLE;
						remaining_q <= '0;
						phase_q     <= '0;
						state_q     <= ST_SHOW;
					end else begin
						lvl_s_q <= apply_floor(s_fix, cfg.strong_floor);
						lvl_w_q <= apply_floor(w_fix, cfg.weak_floor);
						state_q <= ST_COMPARE;
					end
				end
				ST_COMPARE: begin
					if (mag >= cfg.steady_threshold) begin
						mode_q          <= MODE_STEADY;
						steady_strong_q <= lvl_s_q;
						steady_weak_q   <= lvl_w_q;
						remaining_q     <= run_us_q;
						phase_q         <= '0;
						state_q         <= ST_SHOW;
					end else begin
						prod_on_q <= {16'd0, mag} * {16'd0, per};
						state_q   <= ST_ONDIV;
					end
				end
				ST_ONDIV: begin
					est_on_q <= div65535_est(prod_on_q);
					state_q  <= ST_ONFIX;
				end
				ST_ONFIX: begin
					// Zero on time leaves any current run alone
					if (on_fix == '0) begin
						state_q <= ST_SHOW;
					end else if (on_fix >= per) begin
						mode_q          <= MODE_STEADY;
						steady_strong_q <= FULL_LEVEL;
						steady_weak_q   <= FULL_LEVEL;
						remaining_q     <= run_us_q;
						phase_q         <= '0;
						state_q         <= ST_SHOW;
					end else begin
						mode_q      <= MODE_PULSED;
						on_time_q   <= on_fix;
						remaining_q <= run_us_q;
						phase_q     <= '0;
						state_q     <= ST_SHOW;
					end
				end
				ST_SHOW: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						motor_on_q  <= show_on;
						strong_q    <= show_strong;
						weak_q      <= show_weak;
						mode_out_q  <= mode_q;
						state_q     <= ST_WAIT;
					end
				end
				default: begin
					state_q <= ST_WAIT;
				end
			endcase
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.motor_on     = motor_on_q;
	assign out_ch.strong_drive = strong_q;
	assign out_ch.weak_drive   = weak_q;
	assign out_ch.drive_mode   = mode_out_q;

	assign status.mode     = mode_q;
	assign status.rem_zero = remaining_q == '0;

endmodule

// File: src/rumble_motor_pwm_driver.sv
// Rumble motor drive sequencer: top level with configuration registers.
//
// Requests arrive on in_ch: op 0 is a rumble command (strong, weak,
// duration in ms), op 1 is one microsecond tick. Every request gives one
// result on out_ch: motor_on, strong_drive, weak_drive and drive_mode as
// they stand after the request. Registers are written through cfg_wr_en,
// cfg_index and cfg_wdata, one register per cycle; the user must write
// them only while no request is in flight, as the block does not enforce it.
// A request passes a front register and the request queue, then the
// back-end sequencer, which works on one request at a time and takes the
// next only once the result of the last is in the output register. A
// tick, a stop or an ignored command goes straight to the result. A run
// command is scaled, divided by 255 and floored, and ends there when both
// scaled levels are zero; else it is compared with the steady threshold,
// and a pulse train works out its on time by a multiply and a divide by
// 65535 before the result.
// Reset clears the drive state to idle and loads the register defaults.
// When the receiver stalls, the result waits in the output register; the
// sequencer holds, and the queue keeps taking requests until full.
`include "rumble_motor_pwm_driver_assert.svh"

module rumble_motor_pwm_driver import rmpd_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  cfg_idx_t           cfg_index,
	input  logic [LEVEL_W-1:0] cfg_wdata,
	rmpd_in_if.sink            in_ch,
	rmpd_out_if.source         out_ch
);

	cfg_t         cfg_q;
	logic         push_valid;
	logic         push_ready;
	item_t        push_item;
	logic         pop_valid;
	logic         pop_ready;
	item_t        pop_item;
	back_status_t status;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_enable     <= RST_DRIVE_ENABLE;
			cfg_q.intensity        <= RST_INTENSITY;
			cfg_q.steady_threshold <= RST_STEADY_THRESHOLD;
			cfg_q.pulse_period_us  <= RST_PULSE_PERIOD;
			cfg_q.strong_floor     <= RST_STRONG_FLOOR;
			cfg_q.weak_floor       <= RST_WEAK_FLOOR;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_DRIVE_ENABLE:     cfg_q.drive_enable     <= cfg_wdata[0];
				CFG_INTENSITY:        cfg_q.intensity        <= cfg_wdata[7:0];
				CFG_STEADY_THRESHOLD: cfg_q.steady_threshold <= cfg_wdata;
				CFG_PULSE_PERIOD:     cfg_q.pulse_period_us  <= cfg_wdata;
				CFG_STRONG_FLOOR:     cfg_q.strong_floor     <= cfg_wdata;
				CFG_WEAK_FLOOR:       cfg_q.weak_floor       <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	rmpd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.drive_enable (cfg_q.drive_enable),
		.in_ch        (in_ch),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_item    (push_item)
	);

	rmpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	rmpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_ch    (out_ch),
		.status    (status)
	);

	// An idle motor has no run time left
	`RMPD_ASSERT_HOLDS(a_idle_no_time, clk, arst_n, status.mode == MODE_IDLE, status.rem_zero)
	// An idle result drives nothing
	`RMPD_ASSERT_HOLDS(a_idle_result_off, clk, arst_n, out_ch.valid && out_ch.drive_mode == MODE_IDLE, !out_ch.motor_on && out_ch.strong_drive == '0 && out_ch.weak_drive == '0)
	// A pulse on phase drives full strength on both motors
	`RMPD_ASSERT_HOLDS(a_pulse_full, clk, arst_n, out_ch.valid && out_ch.motor_on && out_ch.drive_mode == MODE_PULSED, out_ch.strong_drive == FULL_LEVEL && out_ch.weak_drive == FULL_LEVEL)
	// The sequencer works on one request at a time
	`RMPD_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, pop_valid && pop_ready, !pop_ready)

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the rumble motor drive sequencer.
module testbench;
	import rmpd_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int MAX_REPORTS   = 40;
	localparam int LONG_HOLD_OFF = 300;
	localparam int TAIL_CYCLES   = 20;
	localparam int RANDOM_ITEMS  = 480;
	localparam int RANDOM_PHASES = 8;

	typedef struct packed {
		logic               op;
		logic [LEVEL_W-1:0] strong_level;
		logic [LEVEL_W-1:0] weak_level;
		logic [LEVEL_W-1:0] duration_ms;
	} rumble_req_t;

	typedef struct packed {
		logic               motor_on;
		logic [LEVEL_W-1:0] strong_drive;
		logic [LEVEL_W-1:0] weak_drive;
		mode_t              drive_mode;
	} drive_state_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	cfg_idx_t           cfg_index;
	logic [LEVEL_W-1:0] cfg_wdata;

	rmpd_in_if  req_ch();
	rmpd_out_if result_ch();

	rumble_motor_pwm_driver DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (req_ch),
		.out_ch    (result_ch)
	);

	// Shadow registers and drive state of the sequencer
	cfg_t                shadow_cfg;
	mode_t               cur_mode;
	logic [LEVEL_W-1:0]  hold_strong;
	logic [LEVEL_W-1:0]  hold_weak;
	logic [LEVEL_W-1:0]  pulse_on_us;
	logic [LEVEL_W-1:0]  pulse_pos_us;
	logic [REMAIN_W-1:0] time_left_us;

	drive_state_t pending_drive[$];

	int cycle_count     = 0;
	int mismatch_count  = 0;
	int results_checked = 0;
	int commands_sent   = 0;
	int ticks_sent      = 0;
	int writes_done     = 0;
	int stall_left      = 0;
	int hold_left       = 0;
	bit tx_calm         = 1'b0;
	bit rx_calm         = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) cycle_count++;

	// Give up after the cycle limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("Timed out after %0d cycles with %0d results outstanding",
			cycle_count, pending_drive.size());
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("[cycle %0d] mismatch: %s", cycle_count, what);
	endtask

	function automatic void reset_drive_model();
		shadow_cfg.drive_enable     = RST_DRIVE_ENABLE;
		shadow_cfg.intensity        = RST_INTENSITY;
		shadow_cfg.steady_threshold = RST_STEADY_THRESHOLD;
		shadow_cfg.pulse_period_us  = RST_PULSE_PERIOD;
		shadow_cfg.strong_floor     = RST_STRONG_FLOOR;
		shadow_cfg.weak_floor       = RST_WEAK_FLOOR;
		cur_mode     = MODE_IDLE;
		hold_strong  = '0;
		hold_weak    = '0;
		pulse_on_us  = '0;
		pulse_pos_us = '0;
		time_left_us = '0;
	endfunction

	// Apply one request to the drive state and return the drive that follows
	function automatic drive_state_t advance_drive(input rumble_req_t r);
		logic [31:0]  s;
		logic [31:0]  w;
		logic [31:0]  mag;
		logic [31:0]  per;
		logic [31:0]  on;
		logic [31:0]  span;
		logic [31:0]  step;
		drive_state_t d;
		per  = (shadow_cfg.pulse_period_us == '0) ? 32'd1 : {16'd0, shadow_cfg.pulse_period_us};
		span = {16'd0, r.duration_ms} * 32'd1000;
		if (r.op == OP_COMMAND) begin
			if (shadow_cfg.drive_enable) begin
				s = ({16'd0, r.strong_level} * {24'd0, shadow_cfg.intensity}) / 32'd255;
				w = ({16'd0, r.weak_level} * {24'd0, shadow_cfg.intensity}) / 32'd255;
				if (r.duration_ms == '0 || (s == 0 && w == 0)) begin
					cur_mode     = MODE_IDLE;
					time_left_us = '0;
					pulse_pos_us = '0;
				end else begin
					// raise nonzero levels to their floors
					if (s != 0 && s < {16'd0, shadow_cfg.strong_floor})
						s = {16'd0, shadow_cfg.strong_floor};
					if (w != 0 && w < {16'd0, shadow_cfg.weak_floor})
						w = {16'd0, shadow_cfg.weak_floor};
					mag = (s > w) ? s : w;
					on  = (mag * per) / 32'd65535;
					if (mag >= {16'd0, shadow_cfg.steady_threshold}) begin
						cur_mode     = MODE_STEADY;
						hold_strong  = s[LEVEL_W-1:0];
						hold_weak    = w[LEVEL_W-1:0];
						time_left_us = span[REMAIN_W-1:0];
						pulse_pos_us = '0;
					end else if (on >= per) begin
						cur_mode     = MODE_STEADY;
						hold_strong  = FULL_LEVEL;
						hold_weak    = FULL_LEVEL;
						time_left_us = span[REMAIN_W-1:0];
						pulse_pos_us = '0;
					end else if (on != 0) begin
						cur_mode     = MODE_PULSED;
						pulse_on_us  = on[LEVEL_W-1:0];
						pulse_pos_us = '0;
						time_left_us = span[REMAIN_W-1:0];
					end
				end
			end
		end else if (cur_mode == MODE_STEADY) begin
			if (time_left_us != '0)
				time_left_us = time_left_us - 1'b1;
			if (time_left_us == '0)
				cur_mode = MODE_IDLE;
		end else if (cur_mode == MODE_PULSED) begin
			if (time_left_us != '0)
				time_left_us = time_left_us - 1'b1;
			step = {16'd0, pulse_pos_us} + 32'd1;
			// wrap at the end of a period; finish the train only there
			if (step >= per) begin
				pulse_pos_us = '0;
				if (time_left_us == '0)
					cur_mode = MODE_IDLE;
			end else begin
				pulse_pos_us = step[LEVEL_W-1:0];
			end
		end

		d = '0;
		d.drive_mode = cur_mode;
		if (cur_mode == MODE_STEADY) begin
			d.motor_on     = 1'b1;
			d.strong_drive = hold_strong;
			d.weak_drive   = hold_weak;
		end else if (cur_mode == MODE_PULSED && pulse_pos_us < pulse_on_us) begin
			d.motor_on     = 1'b1;
			d.strong_drive = FULL_LEVEL;
			d.weak_drive   = FULL_LEVEL;
		end
		return d;
	endfunction

	// Compare each result with the oldest expected drive
	always @(posedge clk) begin : check_results
		drive_state_t want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			results_checked++;
			if (pending_drive.size() == 0) begin
				report_mismatch("result arrived with nothing expected");
			end else begin
				want = pending_drive.pop_front();
				if (result_ch.motor_on !== want.motor_on)
					report_mismatch($sformatf("motor_on %0b, expected %0b",
						result_ch.motor_on, want.motor_on));
				if (result_ch.strong_drive !== want.strong_drive)
					report_mismatch($sformatf("strong_drive %0d, expected %0d",
						result_ch.strong_drive, want.strong_drive));
				if (result_ch.weak_drive !== want.weak_drive)
					report_mismatch($sformatf("weak_drive %0d, expected %0d",
						result_ch.weak_drive, want.weak_drive));
				if (result_ch.drive_mode !== want.drive_mode)
					report_mismatch($sformatf("drive_mode %0d, expected %0d",
						result_ch.drive_mode, want.drive_mode));
			end
			// draw the stall before the next result
			if ($urandom_range(0, 39) == 0)
				rx_calm = !rx_calm;
			stall_left = rx_calm ? 0 : $urandom_range(0, 18);
		end
	end

	// Drive the result ready: long hold-off first, then the per-result stall
	always @(negedge clk) begin
		result_ch.ready <= (hold_left == 0 && stall_left == 0);
		if (hold_left > 0)
			hold_left--;
		else if (stall_left > 0)
			stall_left--;
	end

	// Offer one request after a random gap and record its expected drive
	task automatic send_request(input rumble_req_t r);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid        <= 1'b1;
		req_ch.op           <= r.op;
		req_ch.strong_level <= r.strong_level;
		req_ch.weak_level   <= r.weak_level;
		req_ch.duration_ms  <= r.duration_ms;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		pending_drive.push_back(advance_drive(r));
		if (r.op == OP_TICK)
			ticks_sent++;
		else
			commands_sent++;
	endtask

	task automatic send_command(input logic [LEVEL_W-1:0] s, w, d);
		rumble_req_t r;
		r.op           = OP_COMMAND;
		r.strong_level = s;
		r.weak_level   = w;
		r.duration_ms  = d;
		send_request(r);
	endtask

	task automatic send_tick();
		rumble_req_t r;
		r.op           = OP_TICK;
		r.strong_level = 16'($urandom);
		r.weak_level   = 16'($urandom);
		r.duration_ms  = 16'($urandom);
		send_request(r);
	endtask

	// Drop valid and wait until every expected result has come back
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_drive.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [LEVEL_W-1:0] value);
		settle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_DRIVE_ENABLE:     shadow_cfg.drive_enable     = value[0];
			CFG_INTENSITY:        shadow_cfg.intensity        = value[7:0];
			CFG_STEADY_THRESHOLD: shadow_cfg.steady_threshold = value;
			CFG_PULSE_PERIOD:     shadow_cfg.pulse_period_us  = value;
			CFG_STRONG_FLOOR:     shadow_cfg.strong_floor     = value;
			CFG_WEAK_FLOOR:       shadow_cfg.weak_floor       = value;
			default: ;
		endcase
		writes_done++;
	endtask

	task automatic set_registers(input logic en, input logic [7:0] gain,
			input logic [LEVEL_W-1:0] thr, per, s_floor, w_floor);
		write_register(CFG_DRIVE_ENABLE, {15'd0, en});
		write_register(CFG_INTENSITY, {8'd0, gain});
		write_register(CFG_STEADY_THRESHOLD, thr);
		write_register(CFG_PULSE_PERIOD, per);
		write_register(CFG_STRONG_FLOOR, s_floor);
		write_register(CFG_WEAK_FLOOR, w_floor);
	endtask

	function automatic logic [LEVEL_W-1:0] pick_level();
		case ($urandom_range(0, 5))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(0, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly short runs, now and then a stop or a long run
	function automatic logic [LEVEL_W-1:0] pick_duration();
		case ($urandom_range(0, 7))
			0:       return 16'd0;
			1:       return 16'($urandom);
			default: return 16'($urandom_range(1, 2));
		endcase
	endfunction

	task automatic randomise_registers();
		logic [LEVEL_W-1:0] per;
		logic [LEVEL_W-1:0] thr;
		logic [7:0]         gain;
		case ($urandom_range(0, 7))
			0:       per = 16'd0;
			1:       per = 16'hFFFF;
			2:       per = 16'($urandom);
			default: per = 16'($urandom_range(1, 40));
		endcase
		case ($urandom_range(0, 4))
			0:       thr = 16'd0;
			1:       thr = 16'hFFFF;
			2:       thr = RST_STEADY_THRESHOLD;
			default: thr = 16'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0:       gain = 8'd0;
			1:       gain = 8'd255;
			default: gain = 8'($urandom);
		endcase
		set_registers($urandom_range(0, 7) != 0, gain, thr, per, pick_level(), pick_level());
	endtask

	// Field extremes and every kind of command at the reset settings
	task automatic test_directed_commands();
		send_tick();
		send_command(16'd0, 16'd0, 16'd5);
		send_command(16'hFFFF, 16'd0, 16'd0);
		send_command(16'hFFFF, 16'd0, 16'hFFFF);
		send_tick();
		send_command(16'd100, 16'd100, 16'd3);
		send_tick();
		send_tick();
		send_command(16'd0, 16'hFFFF, 16'd1);
		send_command(16'd1, 16'd1, 16'hFFFF);
		send_tick();
		send_command(16'hFFFF, 16'hFFFF, 16'd0);
		send_command(16'd59999, 16'd0, 16'd2);
		send_tick();
		send_command(16'd60000, 16'd0, 16'd2);
		send_command(16'd0, 16'd59999, 16'd7);
		send_command(16'hAAAA, 16'h5555, 16'hAAAA);
		send_command(16'h5555, 16'hAAAA, 16'h5555);
		send_tick();
		send_command(16'd0, 16'd0, 16'd0);
		send_tick();
		settle();
	endtask

	// Register extremes and the corner cases they open up
	task automatic test_register_extremes();
		// zero gain turns every command into a stop
		set_registers(1'b1, 8'd0, RST_STEADY_THRESHOLD, RST_PULSE_PERIOD,
			RST_STRONG_FLOOR, RST_WEAK_FLOOR);
		send_command(16'hFFFF, 16'hFFFF, 16'd5);
		send_tick();
		// zero threshold: any nonzero level runs steady, floors at both ends
		set_registers(1'b1, 8'd255, 16'd0, RST_PULSE_PERIOD, 16'hFFFF, 16'd0);
		send_command(16'd1, 16'd0, 16'd1);
		send_command(16'd0, 16'd1, 16'd1);
		send_tick();
		// disabled: commands leave the run alone, ticks still count down
		write_register(CFG_DRIVE_ENABLE, 16'd0);
		send_command(16'd0, 16'd0, 16'd0);
		send_command(16'hFFFF, 16'hFFFF, 16'd9);
		send_tick();
		send_tick();
		// a level too small for the period gives no on time: the train goes on
		set_registers(1'b1, 8'd255, 16'hFFFF, 16'd3, 16'd0, 16'd0);
		send_command(16'd40000, 16'd0, 16'd1);
		send_command(16'd1, 16'd0, 16'd5);
		repeat (4) send_tick();
		// shrink the period below the current position: wrap on the next tick
		write_register(CFG_PULSE_PERIOD, 16'd50);
		send_command(16'd0, 16'd32768, 16'd2);
		repeat (30) send_tick();
		write_register(CFG_PULSE_PERIOD, 16'd5);
		repeat (3) send_tick();
		// a zero period behaves as one microsecond
		write_register(CFG_PULSE_PERIOD, 16'd0);
		repeat (3) send_tick();
		send_command(16'd65534, 16'd0, 16'd1);
		// longest period
		write_register(CFG_PULSE_PERIOD, 16'hFFFF);
		send_command(16'd65534, 16'd65534, 16'hFFFF);
		repeat (3) send_tick();
		send_command(16'd0, 16'd0, 16'd1);
		set_registers(RST_DRIVE_ENABLE, RST_INTENSITY, RST_STEADY_THRESHOLD,
			RST_PULSE_PERIOD, RST_STRONG_FLOOR, RST_WEAK_FLOOR);
	endtask

	// Hold the results off while requests keep coming, so the input stalls
	task automatic test_output_stall();
		settle();
		tx_calm   = 1'b1;
		hold_left = LONG_HOLD_OFF;
		send_command(16'd20000, 16'd0, 16'd3);
		repeat (40) send_tick();
		settle();
	endtask

	// Let a pulse train time out on its own
	task automatic test_run_to_expiry();
		set_registers(1'b1, 8'd255, RST_STEADY_THRESHOLD, 16'd7,
			RST_STRONG_FLOOR, RST_WEAK_FLOOR);
		// time runs out mid-period; the train finishes that period off
		send_command(16'd30000, 16'd0, 16'd1);
		repeat (1010) send_tick();
		settle();
	endtask

	// Random settings per phase; mostly commands followed by tick bursts
	task automatic test_random_traffic();
		int          goal;
		int          burst;
		rumble_req_t r;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			randomise_registers();
			goal = commands_sent + ticks_sent + RANDOM_ITEMS / RANDOM_PHASES;
			while (commands_sent + ticks_sent < goal) begin
				case ($urandom_range(0, 9))
					8: begin
						r.op           = 1'($urandom_range(0, 1));
						r.strong_level = 16'($urandom);
						r.weak_level   = 16'($urandom);
						r.duration_ms  = 16'($urandom);
						send_request(r);
					end
					9: begin
						send_command(pick_level(), pick_level(), 16'd0);
						repeat ($urandom_range(0, 5)) send_tick();
					end
					default: begin
						send_command(pick_level(), pick_level(), pick_duration());
						burst = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60)
							: $urandom_range(0, 8);
						repeat (burst) send_tick();
					end
				endcase
			end
		end
		settle();
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_index           = CFG_DRIVE_ENABLE;
		cfg_wdata           = '0;
		req_ch.valid        = 1'b0;
		req_ch.op           = OP_TICK;
		req_ch.strong_level = '0;
		req_ch.weak_level   = '0;
		req_ch.duration_ms  = '0;
		result_ch.ready     = 1'b0;
		reset_drive_model();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_commands();
		test_register_extremes();
		test_output_stall();
		test_run_to_expiry();
		test_random_traffic();

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d commands and %0d ticks across %0d register writes,",
			commands_sent, ticks_sent, writes_done);
		$display("with a %0d-cycle output hold-off; %0d results checked, %0d mismatches.",
			LONG_HOLD_OFF, results_checked, mismatch_count);
		if (mismatch_count == 0 && pending_drive.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
